FILE: rtl/tgsb_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map and constants for the tach gauge block.
package tgsb_pkg;

    localparam int SPEED_W      = 16;
    localparam int MS_W         = 10;
    localparam int SCALE_W      = 8;
    localparam int GAUGE_W      = 15;
    localparam int PRODUCT_W    = SPEED_W + SCALE_W;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [GAUGE_W-1:0] GAUGE_MAX = {GAUGE_W{1'b1}};

    // Register indexes; byte address is four times the index.
    localparam logic [REG_IDX_W-1:0] REG_ROUND_STEP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TACH_MIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REDLINE      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_SPEED  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CHANGE_FILT  = 3'd6;

    // Register reset values.
    localparam logic [SPEED_W-1:0] RST_ROUND_STEP   = 16'd50;
    localparam logic [SPEED_W-1:0] RST_TACH_MIN     = 16'd3000;
    localparam logic [SPEED_W-1:0] RST_REDLINE      = 16'd13000;
    localparam logic [SCALE_W-1:0] RST_FULL_SCALE   = 8'd100;
    localparam logic [SPEED_W-1:0] RST_SHIFT_SPEED  = 16'd12000;
    localparam logic [MS_W-1:0]    RST_BLINK_PERIOD = 10'd500;
    localparam logic [SPEED_W-1:0] RST_CHANGE_FILT  = 16'd125;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

endpackage

FILE: rtl/tgsb_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
module tgsb_div #(
    parameter int DIVIDEND_W = tgsb_pkg::SPEED_W,
    parameter int DIVISOR_W  = tgsb_pkg::SPEED_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg,  busy_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg,   quo_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // The dividend shifts out of quo_reg at the top while quotient bits enter at the bottom.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/tach_gauge_shift_blink.sv
`timescale 1ns / 1ps
// Top level: tach gauge scaling, digit rounding and shift-light blinking.
// A new item is taken only after the previous result has moved into the output register.
// The 24-step bit-serial gauge divider is the longest of the three dividers.
// The rounding and blink remainders run on their own 16- and 10-step dividers in parallel.
// Reset (aresetn low, synchronous) loads the register defaults and clears the last shown speed.
// The output register holds a finished result while the next item is taken in.
module tach_gauge_shift_blink (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tgsb_pkg::SPEED_W-1:0]        s_speed,
    input  logic [tgsb_pkg::MS_W-1:0]           s_ms_in_second,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tgsb_pkg::SPEED_W-1:0]        m_digits_value,
    output logic                                m_gauge_write,
    output logic [tgsb_pkg::GAUGE_W-1:0]        m_gauge_value,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgsb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tgsb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tgsb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import tgsb_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. A write lands on the access phase of the
    // transfer; the port never inserts wait states.
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] round_step_reg,   round_step_next;
    logic [SPEED_W-1:0] tach_min_reg,     tach_min_next;
    logic [SPEED_W-1:0] redline_reg,      redline_next;
    logic [SCALE_W-1:0] full_scale_reg,   full_scale_next;
    logic [SPEED_W-1:0] shift_speed_reg,  shift_speed_next;
    logic [MS_W-1:0]    blink_period_reg, blink_period_next;
    logic [SPEED_W-1:0] change_filt_reg,  change_filt_next;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];

    always_comb begin
        round_step_next   = round_step_reg;
        tach_min_next     = tach_min_reg;
        redline_next      = redline_reg;
        full_scale_next   = full_scale_reg;
        shift_speed_next  = shift_speed_reg;
        blink_period_next = blink_period_reg;
        change_filt_next  = change_filt_reg;
        if (cfg_write) begin
            unique case (cfg_idx)
                REG_ROUND_STEP:   round_step_next   = pwdata[SPEED_W-1:0];
                REG_TACH_MIN:     tach_min_next     = pwdata[SPEED_W-1:0];
                REG_REDLINE:      redline_next      = pwdata[SPEED_W-1:0];
                REG_FULL_SCALE:   full_scale_next   = pwdata[SCALE_W-1:0];
                REG_SHIFT_SPEED:  shift_speed_next  = pwdata[SPEED_W-1:0];
                REG_BLINK_PERIOD: blink_period_next = pwdata[MS_W-1:0];
                REG_CHANGE_FILT:  change_filt_next  = pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROUND_STEP:   prdata = APB_DATA_W'(round_step_reg);
            REG_TACH_MIN:     prdata = APB_DATA_W'(tach_min_reg);
            REG_REDLINE:      prdata = APB_DATA_W'(redline_reg);
            REG_FULL_SCALE:   prdata = APB_DATA_W'(full_scale_reg);
            REG_SHIFT_SPEED:  prdata = APB_DATA_W'(shift_speed_reg);
            REG_BLINK_PERIOD: prdata = APB_DATA_W'(blink_period_reg);
            REG_CHANGE_FILT:  prdata = APB_DATA_W'(change_filt_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_step_reg   <= RST_ROUND_STEP;
            tach_min_reg     <= RST_TACH_MIN;
            redline_reg      <= RST_REDLINE;
            full_scale_reg   <= RST_FULL_SCALE;
            shift_speed_reg  <= RST_SHIFT_SPEED;
            blink_period_reg <= RST_BLINK_PERIOD;
            change_filt_reg  <= RST_CHANGE_FILT;
        end else begin
            round_step_reg   <= round_step_next;
            tach_min_reg     <= tach_min_next;
            redline_reg      <= redline_next;
            full_scale_reg   <= full_scale_next;
            shift_speed_reg  <= shift_speed_next;
            blink_period_reg <= blink_period_next;
            change_filt_reg  <= change_filt_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. IDLE takes a transfer, PREP registers the product and the
    // comparison flags, LAUNCH starts the three dividers, and WAIT hands
    // the result to the output register once the dividers are done and
    // the output register is free.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic div_busy_any;
    logic out_free;
    logic prep_en;
    logic launch;
    logic finish;

    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT:   if (!div_busy_any && out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        prep_en = 1'b0;
        launch  = 1'b0;
        finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_PREP:   prep_en = 1'b1;
            ST_LAUNCH: launch  = 1'b1;
            ST_WAIT:   finish  = !div_busy_any && out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Item datapath.
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0]   speed_reg,      speed_next;
    logic [MS_W-1:0]      ms_reg,         ms_next;
    logic [PRODUCT_W-1:0] product_reg,    product_next;
    logic                 above_min_reg,  above_min_next;
    logic                 above_shift_reg, above_shift_next;
    logic                 moved_reg,      moved_next;
    logic                 span_ok_reg,    span_ok_next;
    logic [SPEED_W-1:0]   last_shown_reg, last_shown_next;

    logic [SPEED_W-1:0]   speed_over_min;
    logic [SPEED_W-1:0]   span;
    logic [SPEED_W-1:0]   speed_delta;

    assign speed_over_min = speed_reg - tach_min_reg;
    assign span           = redline_reg - tach_min_reg;
    assign speed_delta    = (speed_reg > last_shown_reg) ? (speed_reg - last_shown_reg)
                                                         : (last_shown_reg - speed_reg);

    always_comb begin
        speed_next       = speed_reg;
        ms_next          = ms_reg;
        product_next     = product_reg;
        above_min_next   = above_min_reg;
        above_shift_next = above_shift_reg;
        moved_next       = moved_reg;
        span_ok_next     = span_ok_reg;
        if (s_valid && s_ready) begin
            speed_next = s_speed;
            ms_next    = s_ms_in_second;
        end
        if (prep_en) begin
            product_next     = PRODUCT_W'(full_scale_reg) * PRODUCT_W'(speed_over_min);
            above_min_next   = speed_reg > tach_min_reg;
            above_shift_next = speed_reg > shift_speed_reg;
            moved_next       = speed_delta > change_filt_reg;
            span_ok_next     = redline_reg > tach_min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        speed_reg       <= speed_next;
        ms_reg          <= ms_next;
        product_reg     <= product_next;
        above_min_reg   <= above_min_next;
        above_shift_reg <= above_shift_next;
        moved_reg       <= moved_next;
        span_ok_reg     <= span_ok_next;
    end

    // Three serial dividers share the launch strobe and run side by side.
    logic                 round_busy, gauge_busy, blink_busy;
    logic [SPEED_W-1:0]   round_quo;
    logic [SPEED_W-1:0]   round_rem;
    logic [PRODUCT_W-1:0] gauge_quo;
    logic [SPEED_W-1:0]   gauge_rem;
    logic [MS_W-1:0]      blink_quo;
    logic [MS_W-1:0]      blink_rem;

    tgsb_div #(
        .DIVIDEND_W (SPEED_W),
        .DIVISOR_W  (SPEED_W)
    ) u_round_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (launch),
        .dividend  (speed_reg),
        .divisor   (round_step_reg),
        .busy      (round_busy),
        .quotient  (round_quo),
        .remainder (round_rem)
    );

    tgsb_div #(
        .DIVIDEND_W (PRODUCT_W),
        .DIVISOR_W  (SPEED_W)
    ) u_gauge_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (launch),
        .dividend  (product_reg),
        .divisor   (span),
        .busy      (gauge_busy),
        .quotient  (gauge_quo),
        .remainder (gauge_rem)
    );

    tgsb_div #(
        .DIVIDEND_W (MS_W),
        .DIVISOR_W  (MS_W)
    ) u_blink_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (launch),
        .dividend  (ms_reg),
        .divisor   (blink_period_reg),
        .busy      (blink_busy),
        .quotient  (blink_quo),
        .remainder (blink_rem)
    );

    assign div_busy_any = round_busy || gauge_busy || blink_busy;

    // Only remainders are needed from the rounding and blink dividers, and
    // only the quotient from the gauge divider.
    logic unused_div_bits;
    assign unused_div_bits = ^{round_quo, gauge_rem, blink_quo};

    // Result assembly. A zero round step passes the speed through. The
    // blink is off in the first half of the period; with a period of zero
    // or one the half period is zero and the gauge is never forced off.
    logic [GAUGE_W-1:0] scaled;
    logic               blink_off;
    logic               gauge_write;

    assign scaled = !span_ok_reg ? '0 :
                    (gauge_quo > PRODUCT_W'(GAUGE_MAX)) ? GAUGE_MAX :
                    gauge_quo[GAUGE_W-1:0];
    assign blink_off   = blink_rem < {1'b0, blink_period_reg[MS_W-1:1]};
    assign gauge_write = above_min_reg && (above_shift_reg || moved_reg);

    // Below the shift point a gauge update also moves the last shown speed.
    always_comb begin
        last_shown_next = last_shown_reg;
        if (finish && above_min_reg && !above_shift_reg && moved_reg) begin
            last_shown_next = speed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_shown_reg <= '0;
        end else begin
            last_shown_reg <= last_shown_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result until the transfer on
    // the result channel, independent of the input side.
    // ------------------------------------------------------------------
    logic               m_valid_reg,  m_valid_next;
    logic [SPEED_W-1:0] m_digits_reg, m_digits_next;
    logic               m_write_reg,  m_write_next;
    logic [GAUGE_W-1:0] m_gauge_reg,  m_gauge_next;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_digits_next = m_digits_reg;
        m_write_next  = m_write_reg;
        m_gauge_next  = m_gauge_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (finish) begin
            m_valid_next  = 1'b1;
            m_digits_next = (round_step_reg == '0) ? speed_reg : (speed_reg - round_rem);
            m_write_next  = gauge_write;
            m_gauge_next  = (!gauge_write || (above_shift_reg && blink_off)) ? '0 : scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_digits_reg <= m_digits_next;
        m_write_reg  <= m_write_next;
        m_gauge_reg  <= m_gauge_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_digits_value = m_digits_reg;
    assign m_gauge_write  = m_write_reg;
    assign m_gauge_value  = m_gauge_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A new item is never taken while a divider still works on the last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy_any)
        else $error("input taken while a divider is busy");

    // A result without a gauge update carries a zero gauge value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_gauge_write) |-> (m_gauge_value == '0))
        else $error("gauge value set without gauge write");

    // The last shown speed only moves when a result is handed over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(last_shown_reg) |-> $past(finish))
        else $error("last shown speed changed outside result hand-over");

    // The output register is loaded only when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> (!m_valid || m_ready))
        else $error("result loaded over a pending result");

endmodule

FILE: sim/tb_tach_gauge_shift_blink.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tach gauge, digit readout and shift-blink block.
module tb_tach_gauge_shift_blink;

    import tgsb_pkg::*;

    // Even the long receiver hold-off below stays far under this limit on cycles
    // without any transfer.
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [MS_W-1:0]    ms;
    } speed_sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0] digits;
        logic               gauge_write;
        logic [GAUGE_W-1:0] gauge;
    } readout_t;

    // Clock, reset and every block input start from known values.
    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [SPEED_W-1:0]    s_speed        = '0;
    logic [MS_W-1:0]       s_ms_in_second = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [SPEED_W-1:0]    m_digits_value;
    logic                  m_gauge_write;
    logic [GAUGE_W-1:0]    m_gauge_value;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Our own copy of the register file and of the last shown speed.
    logic [SPEED_W-1:0] cfg_round_step   = RST_ROUND_STEP;
    logic [SPEED_W-1:0] cfg_tach_min     = RST_TACH_MIN;
    logic [SPEED_W-1:0] cfg_redline      = RST_REDLINE;
    logic [SCALE_W-1:0] cfg_full_scale   = RST_FULL_SCALE;
    logic [SPEED_W-1:0] cfg_shift_speed  = RST_SHIFT_SPEED;
    logic [MS_W-1:0]    cfg_blink_period = RST_BLINK_PERIOD;
    logic [SPEED_W-1:0] cfg_change_filt  = RST_CHANGE_FILT;
    logic [SPEED_W-1:0] last_shown_speed = '0;

    speed_sample_t sample_q[$];   // samples waiting to be offered
    readout_t      readout_q[$];  // expected readouts, oldest first
    speed_sample_t next_sample;
    readout_t      got_readout;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_toggle    = 1'b0;
    bit hold_seen      = 1'b0;
    int hold_left      = 0;
    int walk_speed     = 0;
    int idle_cycles    = 0;
    int fail_cnt       = 0;
    int sample_cnt     = 0;
    int readout_cnt    = 0;
    int gauge_upd_cnt  = 0;
    int setting_cnt    = 1;

    tach_gauge_shift_blink DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_speed        (s_speed),
        .s_ms_in_second (s_ms_in_second),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digits_value (m_digits_value),
        .m_gauge_write  (m_gauge_write),
        .m_gauge_value  (m_gauge_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out the readout for one sample and advances the last shown speed.
    function automatic readout_t predict_readout(input logic [SPEED_W-1:0] spd,
                                                 input logic [MS_W-1:0] ms);
        logic [31:0] span;
        logic [31:0] level;
        logic [31:0] phase;
        logic [31:0] diff;
        readout_t    r;
        r.digits      = spd;
        r.gauge_write = 1'b0;
        r.gauge       = '0;
        // A zero step leaves the speed unrounded.
        if (cfg_round_step != 0)
            r.digits = spd - (spd % cfg_round_step);
        if (spd > cfg_tach_min) begin
            // Linear scale from the minimum up to redline; a redline at or below the
            // minimum gives a flat zero gauge.
            level = 0;
            if (cfg_redline > cfg_tach_min) begin
                span  = 32'(cfg_redline) - 32'(cfg_tach_min);
                level = (32'(cfg_full_scale) * (32'(spd) - 32'(cfg_tach_min))) / span;
                if (level > 32'(GAUGE_MAX))
                    level = 32'(GAUGE_MAX);
            end
            if (spd > cfg_shift_speed) begin
                // Shift light: the gauge is blanked during the first half of each
                // blink period. A zero period uses the millisecond as it stands.
                phase = 32'(ms);
                if (cfg_blink_period != 0)
                    phase = 32'(ms) % 32'(cfg_blink_period);
                if (phase < 32'(cfg_blink_period) / 2)
                    level = 0;
                r.gauge_write = 1'b1;
                r.gauge       = level[GAUGE_W-1:0];
            end else begin
                // Below the shift point only a change beyond the filter redraws the gauge.
                diff = (spd > last_shown_speed) ? 32'(spd - last_shown_speed)
                                                : 32'(last_shown_speed - spd);
                if (diff > 32'(cfg_change_filt)) begin
                    last_shown_speed = spd;
                    r.gauge_write    = 1'b1;
                    r.gauge          = level[GAUGE_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // Input driver. Valid is raised without looking at ready and is held with a
    // stable payload until the transfer happens.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_sample = sample_q.pop_front();
                s_valid        <= 1'b1;
                s_speed        <= next_sample.speed;
                s_ms_in_second <= next_sample.ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver. A hold-off keeps ready low for a long stretch so that the
    // block fills up and stalls its input while the driver keeps offering samples.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. A result transfer is checked before any input transfer of the same
    // edge is predicted, so the order of the two never matters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                readout_cnt++;
                if (m_gauge_write)
                    gauge_upd_cnt++;
                if (readout_q.size() == 0) begin
                    $error("result transfer with no readout expected: digits_value %0d",
                           m_digits_value);
                    fail_cnt++;
                end else begin
                    got_readout = readout_q.pop_front();
                    if (m_digits_value !== got_readout.digits) begin
                        $error("digits_value: expected %0d, got %0d",
                               got_readout.digits, m_digits_value);
                        fail_cnt++;
                    end
                    if (m_gauge_write !== got_readout.gauge_write) begin
                        $error("gauge_write: expected %0d, got %0d",
                               got_readout.gauge_write, m_gauge_write);
                        fail_cnt++;
                    end
                    if (m_gauge_value !== got_readout.gauge) begin
                        $error("gauge_value: expected %0d, got %0d",
                               got_readout.gauge, m_gauge_value);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                sample_cnt++;
                readout_q.push_back(predict_readout(s_speed, s_ms_in_second));
            end
        end
    end

    // Watchdog on cycles in which no transfer of any kind takes place.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[tach_gauge_shift_blink] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One register write: a setup cycle, then an access cycle. The model copy is
    // updated at the edge where the block takes the value.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROUND_STEP:   cfg_round_step   = value[SPEED_W-1:0];
            REG_TACH_MIN:     cfg_tach_min     = value[SPEED_W-1:0];
            REG_REDLINE:      cfg_redline      = value[SPEED_W-1:0];
            REG_FULL_SCALE:   cfg_full_scale   = value[SCALE_W-1:0];
            REG_SHIFT_SPEED:  cfg_shift_speed  = value[SPEED_W-1:0];
            REG_BLINK_PERIOD: cfg_blink_period = value[MS_W-1:0];
            REG_CHANGE_FILT:  cfg_change_filt  = value[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int step, input int min_spd, input int red,
                              input int scale, input int shift, input int blink,
                              input int filt);
        write_reg(REG_ROUND_STEP,   step);
        write_reg(REG_TACH_MIN,     min_spd);
        write_reg(REG_REDLINE,      red);
        write_reg(REG_FULL_SCALE,   scale);
        write_reg(REG_SHIFT_SPEED,  shift);
        write_reg(REG_BLINK_PERIOD, blink);
        write_reg(REG_CHANGE_FILT,  filt);
        setting_cnt++;
    endtask

    task automatic add_sample(input int spd, input int ms);
        speed_sample_t smp;
        smp.speed = SPEED_W'(spd);
        smp.ms    = MS_W'(ms);
        sample_q.push_back(smp);
    endtask

    // A speed within spread of the centre, clipped to the field's range.
    function automatic int near_speed(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    // Random samples cluster on the thresholds and follow a wandering speed whose
    // steps straddle the change filter, so both gauge paths get real exercise.
    function automatic speed_sample_t random_sample();
        speed_sample_t smp;
        case ($urandom_range(6))
            0:       smp.speed = SPEED_W'($urandom_range(65535));
            1:       smp.speed = SPEED_W'(near_speed(cfg_tach_min, 4));
            2:       smp.speed = SPEED_W'(near_speed(cfg_shift_speed, 4));
            3:       smp.speed = SPEED_W'(near_speed(cfg_redline, 4));
            default: begin
                walk_speed = near_speed(walk_speed, int'(cfg_change_filt) + 50);
                smp.speed  = SPEED_W'(walk_speed);
            end
        endcase
        // Milliseconds past 999 are legal on the port and show up now and then.
        if ($urandom_range(9) == 0)
            smp.ms = MS_W'($urandom_range(1023));
        else
            smp.ms = MS_W'($urandom_range(999));
        return smp;
    endfunction

    // Waits until every sample has been sent and every readout has come back,
    // then lets the pipeline settle before the registers are touched again.
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_valid || readout_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input int send_pct, input int recv_pct,
                              input bit hold);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        walk_speed     = cfg_shift_speed;
        for (int i = 0; i < count; i++)
            sample_q.push_back(random_sample());
        if (hold)
            hold_toggle = ~hold_toggle;
        wait_drained();
    endtask

    initial begin
        int min_spd;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed samples at the reset settings: readout rounding, the minimum
        // speed edge, the change filter edge, the shift point and the blink phases,
        // redline, top speed and milliseconds beyond the second.
        @(negedge aclk);
        add_sample(0, 0);
        add_sample(49, 5);
        add_sample(99, 1);
        add_sample(3000, 0);
        add_sample(3001, 0);
        add_sample(3100, 0);
        add_sample(3126, 0);
        add_sample(3127, 0);
        add_sample(12000, 0);
        add_sample(12001, 249);
        add_sample(12001, 250);
        add_sample(12001, 499);
        add_sample(12001, 500);
        add_sample(12001, 999);
        add_sample(12001, 1000);
        add_sample(12001, 1023);
        add_sample(13000, 700);
        add_sample(65535, 300);
        add_sample(65535, 0);
        add_sample(6000, 600);
        add_sample(5990, 1);
        add_sample(32768, 512);
        add_sample(65535, 1023);
        wait_drained();

        run_random(35, 0, 0, 1'b0);
        run_random(35, 9, 9, 1'b1);

        // Unrounded readout, the widest gauge range and a zero change filter.
        set_config(0, 0, 65535, 255, 65535, 1000, 0);
        run_random(35, 60, 0, 1'b0);

        // Redline below the minimum keeps the gauge at zero; a zero blink period
        // never blanks it; a full-width filter blocks every update below shift.
        set_config(65535, 1000, 500, 1, 0, 0, 65535);
        run_random(35, 0, 60, 1'b0);

        // A one-count span drives the gauge into saturation; a blink period of one
        // never blanks it.
        set_config(1, 100, 101, 255, 20000, 1, 10);
        run_random(35, 9, 9, 1'b1);

        // Equal minimum and redline, the shortest legal blink, longest period field.
        set_config(7, 0, 0, 1, 0, 2, 300);
        run_random(40, 0, 0, 1'b0);
        set_config(300, 2000, 9000, 200, 6000, 1023, 300);
        run_random(40, 60, 0, 1'b0);

        // Back to the reset values, then a few random settings.
        set_config(RST_ROUND_STEP, RST_TACH_MIN, RST_REDLINE, RST_FULL_SCALE,
                   RST_SHIFT_SPEED, RST_BLINK_PERIOD, RST_CHANGE_FILT);
        run_random(40, 0, 60, 1'b0);
        for (int k = 0; k < 3; k++) begin
            min_spd = $urandom_range(20000);
            set_config($urandom_range(1, 500), min_spd,
                       near_speed(min_spd + 20000, 20000), $urandom_range(1, 255),
                       $urandom_range(65535), $urandom_range(2, 1000),
                       $urandom_range(2000));
            run_random(35, (k == 1) ? 60 : 9, (k == 2) ? 60 : 9, 1'b0);
        end

        if (readout_q.size() != 0) begin
            $error("%0d expected readouts never arrived", readout_q.size());
            fail_cnt++;
        end
        $display("Sent %0d speed samples under %0d register settings.",
                 sample_cnt, setting_cnt);
        $display("Checked %0d readouts, %0d of them gauge updates; %0d mismatches.",
                 readout_cnt, gauge_upd_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("[tach_gauge_shift_blink] OK");
        else
            $display("[tach_gauge_shift_blink] ERROR");
        $finish;
    end

endmodule
